// ----- src/ssfb_pkg.sv -----
// ----------------------------------------------------------------------------
// ssfb_pkg
// Shared types, constants and the hex segment table for the frame builder.
// ----------------------------------------------------------------------------
package ssfb_pkg;

    localparam int IMAGE_BYTES = 16;
    localparam int DIGITS      = 8;
    localparam int IMG_AW      = $clog2(IMAGE_BYTES);
    localparam int FLUSH_LEN   = IMAGE_BYTES + 2;
    localparam int CNT_W       = $clog2(FLUSH_LEN);

    localparam int IN_DATA_W   = 104;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int OUT_USER_W  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] RST_DATA_WRITE  = 8'h40;
    localparam logic [7:0] RST_ADDR_BASE   = 8'hC0;
    localparam logic [7:0] RST_DISPLAY_ON  = 8'h88;
    localparam logic [7:0] RST_DISPLAY_OFF = 8'h80;
    localparam logic [7:0] RST_NO_DOT      = 8'hFF;
    localparam logic [3:0] RST_BRIGHTNESS  = 4'd7;
    localparam logic [3:0] MAX_LEVEL       = 4'd8;

    typedef enum logic [1:0] {
        KIND_DIGITS = 2'd0,
        KIND_LED    = 2'd1,
        KIND_BRIGHT = 2'd2,
        KIND_CLEAR  = 2'd3
    } item_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_WRITE  = 3'd0,
        CFG_ADDR_BASE   = 3'd1,
        CFG_DISPLAY_ON  = 3'd2,
        CFG_DISPLAY_OFF = 3'd3,
        CFG_NO_DOT      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_PARAM = 2'd1,
        STAT_BAD_VALUE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_FLUSH,
        MODE_OFF,
        MODE_ON,
        MODE_STATUS
    } resp_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic capture;   // latch the input item
        logic apply;     // validate, update image, pick response
        logic emit;      // load the next result into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
        logic item_last; // result about to be loaded ends the item
    } dp_status_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] nib);
        logic [7:0] pat;
        unique case (nib)
            4'h0: pat = 8'h3F;
            4'h1: pat = 8'h06;
            4'h2: pat = 8'h5B;
            4'h3: pat = 8'h4F;
            4'h4: pat = 8'h66;
            4'h5: pat = 8'h6D;
            4'h6: pat = 8'h7D;
            4'h7: pat = 8'h07;
            4'h8: pat = 8'h7F;
            4'h9: pat = 8'h6F;
            4'hA: pat = 8'h77;
            4'hB: pat = 8'h7C;
            4'hC: pat = 8'h39;
            4'hD: pat = 8'h5E;
            4'hE: pat = 8'h79;
            4'hF: pat = 8'h71;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

// ----- src/ssfb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssfb_ctrl
// Sequencer: accept one item, decode it, then stream its results.
// ----------------------------------------------------------------------------
module ssfb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ssfb_pkg::dp_status_t sts,
    output ssfb_pkg::ctrl_cmd_t  cmd
);
    import ssfb_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free && sts.item_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        cmd.emit    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE:
            begin
                cmd.apply = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_DECODE)
        else $error("accepted item did not move to decode");

    a_decode_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECODE |=> state_reg == S_EMIT)
        else $error("decode did not lead to emit");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && sts.item_last |=> s_tready)
        else $error("not ready after last result of an item");

endmodule

// ----- src/ssfb_datapath.sv -----
// ----------------------------------------------------------------------------
// ssfb_datapath
// Config registers, display image, item decode and the result register.
// ----------------------------------------------------------------------------
module ssfb_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ssfb_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [ssfb_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ssfb_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [ssfb_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [ssfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssfb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  ssfb_pkg::ctrl_cmd_t                 cmd,
    output ssfb_pkg::dp_status_t                sts
);
    import ssfb_pkg::*;

    // config registers
    logic [7:0] data_write_reg;
    logic [7:0] addr_base_reg;
    logic [7:0] display_on_reg;
    logic [7:0] display_off_reg;
    logic [7:0] no_dot_reg;

    // captured item
    item_kind_t          kind_reg;
    logic [8*DIGITS-1:0] digits_reg;
    logic [7:0]          count_reg;
    logic [7:0]          dot_reg;
    logic [7:0]          led_addr_reg;
    logic [7:0]          led_value_reg;
    logic [7:0]          level_reg;

    // block state
    logic [7:0]       image_reg [IMAGE_BYTES];
    logic [7:0]       image_next [IMAGE_BYTES];
    logic [3:0]       brightness_reg;
    logic [3:0]       brightness_next;
    logic             display_enabled_reg;
    logic             display_enabled_next;
    resp_mode_t       mode_reg;
    resp_mode_t       mode_next;
    status_t          status_reg;
    status_t          status_next;
    logic [CNT_W-1:0] cnt_reg;

    // result register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;
    logic                  m_tlast_reg;

    // decode signals
    logic [7:0] pat [DIGITS];
    logic [7:0] digit_img [IMAGE_BYTES];
    logic       bad_param;
    logic       bad_digit;
    logic [3:0] level_clamped;

    // emit signals
    logic [CNT_W-1:0] img_off;
    logic [IMG_AW-1:0] img_idx;
    logic [3:0]       lvl_minus1;
    logic [2:0]       rev;
    logic [7:0]       res_byte;
    logic             res_valid;
    logic             res_fend;
    logic             res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_write_reg  <= RST_DATA_WRITE;
            addr_base_reg   <= RST_ADDR_BASE;
            display_on_reg  <= RST_DISPLAY_ON;
            display_off_reg <= RST_DISPLAY_OFF;
            no_dot_reg      <= RST_NO_DOT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DATA_WRITE:  data_write_reg  <= cfg_data;
                CFG_ADDR_BASE:   addr_base_reg   <= cfg_data;
                CFG_DISPLAY_ON:  display_on_reg  <= cfg_data;
                CFG_DISPLAY_OFF: display_off_reg <= cfg_data;
                CFG_NO_DOT:      no_dot_reg      <= cfg_data;
                default:         no_dot_reg      <= no_dot_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg      <= item_kind_t'(s_tuser);
            digits_reg    <= s_tdata[63:0];
            count_reg     <= s_tdata[71:64];
            dot_reg       <= s_tdata[79:72];
            led_addr_reg  <= s_tdata[87:80];
            led_value_reg <= s_tdata[95:88];
            level_reg     <= s_tdata[103:96];
        end
    end

    // segment patterns per digit, dot in bit 7
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            pat[d] = seg_pattern(digits_reg[8*d +: 4]);
            if (dot_reg == 8'(d) && dot_reg != no_dot_reg)
            begin
                pat[d][7] = 1'b1;
            end
        end
    end

    // transpose: address 2*s, bit (7-d) = segment s of digit d
    always_comb
    begin
        for (int a = 0; a < IMAGE_BYTES; a++)
        begin
            digit_img[a] = '0;
        end
        for (int d = 0; d < DIGITS; d++)
        begin
            for (int s = 0; s < 8; s++)
            begin
                digit_img[2*s][7-d] = pat[d][s];
            end
        end
    end

    always_comb
    begin
        bad_digit = 1'b0;
        for (int d = 0; d < DIGITS; d++)
        begin
            bad_digit = bad_digit | (|digits_reg[8*d+4 +: 4]);
        end
    end

    assign bad_param = (count_reg != 8'(DIGITS)) ||
                       ((dot_reg > 8'd7) && (dot_reg != no_dot_reg));
    assign level_clamped = (level_reg > 8'(MAX_LEVEL)) ? MAX_LEVEL : level_reg[3:0];

    always_comb
    begin
        image_next           = image_reg;
        brightness_next      = brightness_reg;
        display_enabled_next = display_enabled_reg;
        mode_next            = mode_reg;
        status_next          = status_reg;
        if (cmd.apply)
        begin
            mode_next   = MODE_FLUSH;
            status_next = STAT_OK;
            unique case (kind_reg)
                KIND_DIGITS:
                begin
                    if (bad_param)
                    begin
                        mode_next   = MODE_STATUS;
                        status_next = STAT_BAD_PARAM;
                    end
                    else if (bad_digit)
                    begin
                        mode_next   = MODE_STATUS;
                        status_next = STAT_BAD_VALUE;
                    end
                    else
                    begin
                        image_next = digit_img;
                    end
                end
                KIND_LED:
                begin
                    if (led_addr_reg > 8'(IMAGE_BYTES - 1))
                    begin
                        mode_next   = MODE_STATUS;
                        status_next = STAT_BAD_VALUE;
                    end
                    else
                    begin
                        image_next[led_addr_reg[IMG_AW-1:0]] = led_value_reg;
                    end
                end
                KIND_BRIGHT:
                begin
                    brightness_next      = level_clamped;
                    display_enabled_next = (level_clamped != 4'd0);
                    mode_next            = (level_clamped == 4'd0) ? MODE_OFF : MODE_ON;
                end
                KIND_CLEAR:
                begin
                    for (int a = 0; a < IMAGE_BYTES; a++)
                    begin
                        image_next[a] = '0;
                    end
                end
                default:
                begin
                    mode_next = MODE_FLUSH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < IMAGE_BYTES; a++)
            begin
                image_reg[a] <= '0;
            end
            brightness_reg      <= RST_BRIGHTNESS;
            display_enabled_reg <= 1'b0;
            mode_reg            <= MODE_STATUS;
            status_reg          <= STAT_OK;
            cnt_reg             <= '0;
        end
        else
        begin
            image_reg           <= image_next;
            brightness_reg      <= brightness_next;
            display_enabled_reg <= display_enabled_next;
            mode_reg            <= mode_next;
            status_reg          <= status_next;
            if (cmd.apply)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.emit)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // result selection
    assign img_off    = cnt_reg - CNT_W'(2);
    assign img_idx    = img_off[IMG_AW-1:0];
    assign lvl_minus1 = brightness_reg - 4'd1;
    assign rev        = {lvl_minus1[0], lvl_minus1[1], lvl_minus1[2]};

    always_comb
    begin
        res_byte  = '0;
        res_valid = 1'b1;
        res_fend  = 1'b1;
        res_last  = 1'b0;
        unique case (mode_reg)
            MODE_FLUSH:
            begin
                res_last = (cnt_reg == CNT_W'(FLUSH_LEN - 1));
                if (cnt_reg == CNT_W'(0))
                begin
                    res_byte = data_write_reg;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    res_byte = addr_base_reg;
                    res_fend = 1'b0;
                end
                else
                begin
                    res_byte = image_reg[img_idx];
                    res_fend = res_last;
                end
            end
            MODE_OFF:
            begin
                res_byte = display_off_reg;
                res_last = 1'b1;
            end
            MODE_ON:
            begin
                res_last = (cnt_reg == CNT_W'(1));
                res_byte = res_last ? (display_on_reg | {rev, 5'b0}) : display_on_reg;
            end
            MODE_STATUS:
            begin
                res_valid = 1'b0;
                res_fend  = 1'b0;
                res_last  = 1'b1;
            end
            default:
            begin
                res_last = 1'b1;
            end
        endcase
    end

    assign sts.out_free  = !m_tvalid_reg || m_tready;
    assign sts.item_last = res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tdata_reg <= res_byte;
            m_tuser_reg <= {status_reg, res_fend, res_valid};
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid_reg)
        else $error("loaded result not presented");

    a_on_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && mode_reg == MODE_ON |-> display_enabled_reg)
        else $error("display-on sent while display disabled");

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && mode_reg == MODE_STATUS |-> res_last && cnt_reg == CNT_W'(0))
        else $error("status-only item gave more than one result");

endmodule

// ----- src/seven_segment_frame_builder_core.sv -----
// ----------------------------------------------------------------------------
// seven_segment_frame_builder_core
// LED driver frame builder: keeps a 16-byte display image and turns host
// items into command and data bytes for a seven-segment driver chip.
// ----------------------------------------------------------------------------
// Input stream (s_*): one item per handshake; kind in s_tuser, parameters in
// s_tdata. Output stream (m_*): one bus byte per beat, m_tlast marks the last
// result of an input item, m_tuser carries byte-valid, frame-end and status.
// Configuration: cfg_we writes cfg_data to register cfg_index (0..4) at once;
// write only while the block is idle.
// Flow: an accepted item is captured, then decoded in the DECODE state, then
// its results leave at one per cycle while the receiver keeps up, through a
// single output register. An image update or clear gives 18 results; a
// brightness item gives one or two; an invalid item gives one status result.
// s_tready is high only while no item is in work, so the result count of the
// current item sets the accept rate.
// Reset: config registers take their default commands, the image is cleared,
// brightness goes to 7 and the display flag to off; no result is pending.
// Stall: when m_tready is low the pending result holds and the sequencer
// waits; nothing is dropped.
// ----------------------------------------------------------------------------
module seven_segment_frame_builder_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: digit_bytes[63:0], digit_count[71:64], dot_pos[79:72],
    //          led_address[87:80], led_value[95:88], level[103:96]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ssfb_pkg::IN_DATA_W-1:0]      s_tdata,
    // s_tuser: kind[1:0]
    input  logic [ssfb_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: bus_byte[7:0]
    output logic [ssfb_pkg::OUT_DATA_W-1:0]     m_tdata,
    // m_tuser: byte_valid[0], frame_end[1], status[3:2]
    output logic [ssfb_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [ssfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssfb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ssfb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    ssfb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssfb_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
